### rtl/core/mcfe_pkg.sv
// shared types and constants of the color fade engine
// no dependencies
`default_nettype none

package mcfe_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int COLOR_W      = 15;
  localparam int FRAME_W      = 16;
  localparam int COMP_W       = 5;
  localparam int WEIGHT_W     = 9;
  localparam int FRAC_W       = 8;
  localparam int DVD_W        = FRAME_W + FRAC_W;
  localparam int DIV_CNT_W    = $clog2(DVD_W);
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 24;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'h100;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MIX,
    ST_OUT
  } fsm_state_e;

  typedef struct packed {
    logic load;
    logic idx_clear;
    logic idx_inc;
    logic div_start;
    logic div_step;
    logic mix;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_active;
    logic cur_instant;
    logic idx_last;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/core/mcfe_datapath.sv
// channel table, shift-subtract divider and color mixer
// depends on mcfe_pkg
`default_nettype none

module mcfe_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mcfe_pkg::dp_cmd_t                   cmd_i,
  output mcfe_pkg::dp_sts_t                        sts_o,
  input  wire logic [mcfe_pkg::CH_W-1:0]           ld_channel_i,
  input  wire logic [mcfe_pkg::COLOR_W-1:0]        ld_from_i,
  input  wire logic [mcfe_pkg::COLOR_W-1:0]        ld_to_i,
  input  wire logic [mcfe_pkg::FRAME_W-1:0]        ld_frames_i,
  output logic [mcfe_pkg::CH_W-1:0]                out_channel_o,
  output logic [mcfe_pkg::COLOR_W-1:0]             out_color_o,
  output logic                                     out_last_o
);

  localparam int N   = mcfe_pkg::NUM_CHANNELS;
  localparam int CW  = mcfe_pkg::CH_W;
  localparam int FW  = mcfe_pkg::FRAME_W;
  localparam int DW  = mcfe_pkg::DVD_W;
  localparam int WW  = mcfe_pkg::WEIGHT_W;
  localparam int PW  = mcfe_pkg::COMP_W + WW;

  logic [N-1:0]                        active_q, active_d;
  logic [mcfe_pkg::COLOR_W-1:0]        from_q  [N];
  logic [mcfe_pkg::COLOR_W-1:0]        to_q    [N];
  logic [FW-1:0]                       len_q   [N];
  logic [FW-1:0]                       elap_q  [N];

  logic [CW-1:0]                       idx_q, idx_d;
  logic [DW-1:0]                       quo_q, quo_d;
  logic [FW-1:0]                       rem_q, rem_d;
  logic [mcfe_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;

  logic [CW-1:0]                       out_ch_q;
  logic [mcfe_pkg::COLOR_W-1:0]        out_color_q;
  logic                                out_last_q;

  logic [FW-1:0]                       cur_len, cur_elap, divisor, elap_inc;
  logic [mcfe_pkg::COLOR_W-1:0]        cur_from, cur_to, mix_color;
  logic [FW:0]                         rem_sh;
  logic                                sub_ok, any_above, ld_valid;
  logic [WW-1:0]                       w, w_inv;

  function automatic logic [mcfe_pkg::COMP_W-1:0] mix_comp(
    input logic [mcfe_pkg::COMP_W-1:0] a,
    input logic [mcfe_pkg::COMP_W-1:0] b,
    input logic [mcfe_pkg::WEIGHT_W-1:0] wa,
    input logic [mcfe_pkg::WEIGHT_W-1:0] wb
  );
    logic [PW-1:0] sum;
    sum = PW'(a) * PW'(wa) + PW'(b) * PW'(wb);
    return sum[mcfe_pkg::FRAC_W +: mcfe_pkg::COMP_W];
  endfunction

  assign cur_len  = len_q[idx_q];
  assign cur_elap = elap_q[idx_q];
  assign cur_from = from_q[idx_q];
  assign cur_to   = to_q[idx_q];
  assign divisor  = cur_len - FW'(1);
  assign elap_inc = cur_elap + FW'(1);
  assign ld_valid = (int'(ld_channel_i) < N);

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign sub_ok = (rem_sh >= {1'b0, divisor});

  always_comb begin
    any_above = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (i > int'(idx_q) && active_q[i]) begin
        any_above = 1'b1;
      end
    end
  end

  assign w     = (quo_q > DW'(mcfe_pkg::WEIGHT_ONE)) ? mcfe_pkg::WEIGHT_ONE : quo_q[WW-1:0];
  assign w_inv = mcfe_pkg::WEIGHT_ONE - w;

  always_comb begin
    if (cur_len > FW'(1)) begin
      mix_color = {mix_comp(cur_from[14:10], cur_to[14:10], w_inv, w),
                   mix_comp(cur_from[9:5],   cur_to[9:5],   w_inv, w),
                   mix_comp(cur_from[4:0],   cur_to[4:0],   w_inv, w)};
    end else begin
      mix_color = cur_to;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clear) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.div_start) begin
      quo_d = {cur_elap, {mcfe_pkg::FRAC_W{1'b0}}};
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      quo_d = {quo_q[DW-2:0], sub_ok};
      rem_d = sub_ok ? FW'(rem_sh - {1'b0, divisor}) : rem_sh[FW-1:0];
      cnt_d = cnt_q + mcfe_pkg::DIV_CNT_W'(1);
    end
  end

  always_comb begin
    active_d = active_q;
    if (cmd_i.load && ld_valid) begin
      active_d[ld_channel_i] = 1'b1;
    end else if (cmd_i.advance) begin
      active_d[idx_q] = (elap_inc < cur_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.load && ld_valid) begin
      from_q[ld_channel_i] <= ld_from_i;
      to_q[ld_channel_i]   <= ld_to_i;
      len_q[ld_channel_i]  <= ld_frames_i;
      elap_q[ld_channel_i] <= '0;
    end else if (cmd_i.advance) begin
      elap_q[idx_q] <= elap_inc;
    end
    if (cmd_i.mix) begin
      out_ch_q    <= idx_q;
      out_color_q <= mix_color;
      out_last_q  <= !any_above;
    end
  end

  assign sts_o.cur_active  = active_q[idx_q];
  assign sts_o.cur_instant = (cur_len <= FW'(1));
  assign sts_o.idx_last    = (idx_q == CW'(N - 1));
  assign sts_o.div_done    = (cnt_q == mcfe_pkg::DIV_CNT_W'(DW - 1));

  assign out_channel_o = out_ch_q;
  assign out_color_o   = out_color_q;
  assign out_last_o    = out_last_q;

endmodule

`default_nettype wire

### rtl/core/mcfe_ctrl.sv
// sequencer for request handling, channel scan, division and output
// depends on mcfe_pkg
`default_nettype none

module mcfe_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               in_op_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mcfe_pkg::dp_cmd_t       cmd_o,
  input  wire mcfe_pkg::dp_sts_t  sts_i
);

  mcfe_pkg::fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      mcfe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == mcfe_pkg::OP_START) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.idx_clear = 1'b1;
            state_d         = mcfe_pkg::ST_SCAN;
          end
        end
      end
      mcfe_pkg::ST_SCAN: begin
        if (sts_i.cur_active) begin
          if (sts_i.cur_instant) begin
            state_d = mcfe_pkg::ST_MIX;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = mcfe_pkg::ST_DIV;
          end
        end else if (sts_i.idx_last) begin
          state_d = mcfe_pkg::ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      mcfe_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = mcfe_pkg::ST_MIX;
        end
      end
      mcfe_pkg::ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = mcfe_pkg::ST_OUT;
      end
      mcfe_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (sts_i.idx_last) begin
            state_d = mcfe_pkg::ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = mcfe_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_d = mcfe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/multichannel_color_fade_engine_core.sv
// top level of the multichannel BGR555 color fade engine
// depends on mcfe_pkg, mcfe_ctrl and mcfe_datapath
//
//   channel   dir   tdata (low bit up)                            side
//   s_axis    in    channel, start_color, end_color, frame_total   tuser = op
//   m_axis    out   out_channel, out_color                         tlast = last
//
// a start request is taken while idle and loads its channel
// a tick scans the channels in order; each active channel with a multi-frame fade
// goes through the one-bit-per-cycle divider, the mixer and the output register,
// while an instant one skips the divider
// each result waits in the output register until taken, holding the scan
// reset clears all channels to inactive
`default_nettype none

module multichannel_color_fade_engine_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // channel[2:0], start_color[17:3], end_color[32:18], frame_total[48:33]
  input  wire logic [mcfe_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // op
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // out_channel[2:0], out_color[17:3]
  output logic [mcfe_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  output logic                                     m_axis_tlast
);

  mcfe_pkg::dp_cmd_t               cmd;
  mcfe_pkg::dp_sts_t               sts;
  logic [mcfe_pkg::CH_W-1:0]       out_channel;
  logic [mcfe_pkg::COLOR_W-1:0]    out_color;

  mcfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mcfe_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .ld_channel_i  (s_axis_tdata[2:0]),
    .ld_from_i     (s_axis_tdata[17:3]),
    .ld_to_i       (s_axis_tdata[32:18]),
    .ld_frames_i   (s_axis_tdata[48:33]),
    .out_channel_o (out_channel),
    .out_color_o   (out_color),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_color, out_channel};

endmodule

`default_nettype wire

### tb/multichannel_color_fade_engine_core_tb.sv
// testbench for multichannel_color_fade_engine_core: start and tick requests go in on s_axis,
// and each color update is checked against a per-channel fade predictor kept in the bench
// depends on mcfe_pkg and multichannel_color_fade_engine_core
`timescale 1ns / 1ps

module multichannel_color_fade_engine_core_tb;

  import mcfe_pkg::*;

  localparam int          DRAIN_CYCLES = 250;
  localparam int          STALL_LIMIT  = 20000;
  localparam int unsigned WEIGHT_FULL  = WEIGHT_ONE;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [COLOR_W-1:0] color;
    logic               tail;
  } fade_update_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // per-channel fade state of the predictor
  logic               fade_active[NUM_CHANNELS];
  logic [COLOR_W-1:0] fade_from[NUM_CHANNELS];
  logic [COLOR_W-1:0] fade_to[NUM_CHANNELS];
  logic [FRAME_W-1:0] fade_len[NUM_CHANNELS];
  logic [FRAME_W-1:0] fade_elapsed[NUM_CHANNELS];

  fade_update_t pending_updates[$];
  int           mismatch_count;
  int           src_idle_pct;
  int           sink_stall_pct;
  int           quiet_cycles = 0;

  multichannel_color_fade_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [COLOR_W-1:0] fade_color(input int ch);
    int unsigned        w;
    int unsigned        a;
    int unsigned        b;
    int unsigned        mix;
    logic [COLOR_W-1:0] color;
    color = fade_to[ch];
    if (fade_len[ch] > 16'd1) begin
      w = {8'h00, fade_elapsed[ch], 8'h00} / {16'h0000, fade_len[ch] - 16'd1};
      if (w > WEIGHT_FULL) w = WEIGHT_FULL;
      for (int k = 0; k < 3; k++) begin
        a   = {27'd0, fade_from[ch][k*COMP_W +: COMP_W]};
        b   = {27'd0, fade_to[ch][k*COMP_W +: COMP_W]};
        mix = (a * (WEIGHT_FULL - w) + b * w) >> FRAC_W;
        color[k*COMP_W +: COMP_W] = mix[COMP_W-1:0];
      end
    end
    return color;
  endfunction

  function automatic void predict_request(input logic op, input logic [CH_W-1:0] ch,
                                          input logic [COLOR_W-1:0] sc,
                                          input logic [COLOR_W-1:0] ec,
                                          input logic [FRAME_W-1:0] ft);
    int           n;
    fade_update_t upd;
    n = 0;
    if (op == OP_START) begin
      if (int'(ch) < NUM_CHANNELS) begin
        fade_from[ch]    = sc;
        fade_to[ch]      = ec;
        fade_len[ch]     = ft;
        fade_elapsed[ch] = '0;
        fade_active[ch]  = 1'b1;
      end
      return;
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (fade_active[c]) begin
        upd.channel = c[CH_W-1:0];
        upd.color   = fade_color(c);
        upd.tail    = 1'b0;
        pending_updates.push_back(upd);
        n++;
        fade_elapsed[c] = fade_elapsed[c] + 16'd1;
        if (fade_elapsed[c] >= fade_len[c]) fade_active[c] = 1'b0;
      end
    end
    if (n > 0) pending_updates[pending_updates.size()-1].tail = 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_updates
    fade_update_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_updates.size() == 0) begin
        note_mismatch("unrequested result, tdata", 0, 32'(m_axis_tdata));
      end else begin
        want = pending_updates.pop_front();
        if (m_axis_tdata[2:0] !== want.channel)
          note_mismatch("out_channel", 32'(want.channel), 32'(m_axis_tdata[2:0]));
        if (m_axis_tdata[17:3] !== want.color)
          note_mismatch("out_color", 32'(want.color), 32'(m_axis_tdata[17:3]));
        if (m_axis_tlast !== want.tail)
          note_mismatch("last", 32'(want.tail), 32'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic op, input logic [CH_W-1:0] ch,
                              input logic [COLOR_W-1:0] sc, input logic [COLOR_W-1:0] ec,
                              input logic [FRAME_W-1:0] ft);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W-49){1'b0}}, ft, ec, sc, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(op, ch, sc, ec, ft);
  endtask

  // tick fields other than op carry random junk
  task automatic send_tick();
    send_request(OP_TICK, CH_W'($urandom_range(7)), COLOR_W'($urandom_range(32767)),
                 COLOR_W'($urandom_range(32767)), FRAME_W'($urandom_range(65535)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_empty_tick();
    send_tick();
  endtask

  task automatic test_instant_fades();
    send_request(OP_START, 3'd0, 15'h0000, 15'h7fff, 16'd0);
    send_request(OP_START, 3'd7, 15'h7fff, 15'h0000, 16'd1);
    send_tick();
    send_tick();
  endtask

  task automatic test_extreme_fades();
    send_request(OP_START, 3'd1, 15'h0000, 15'h7fff, 16'd2);
    send_request(OP_START, 3'd2, 15'h7fff, 15'h0000, 16'hffff);
    send_request(OP_START, 3'd3, 15'h5555, 15'h2aaa, 16'd3);
    repeat (3) send_tick();
  endtask

  task automatic test_restart_active();
    send_request(OP_START, 3'd2, 15'h1234, 15'h4321, 16'd2);
    repeat (2) send_tick();
  endtask

  task automatic test_all_channels();
    for (int c = 0; c < NUM_CHANNELS; c++)
      send_request(OP_START, c[CH_W-1:0], COLOR_W'($urandom_range(32767)),
                   COLOR_W'($urandom_range(32767)), c[FRAME_W-1:0]);
    send_tick();
  endtask

  task automatic test_random_phase(input int count, input int src_pct, input int sink_pct);
    int unsigned        pick;
    logic [FRAME_W-1:0] ft;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 45) begin
        send_tick();
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      ft = FRAME_W'($urandom_range(6));
        else if (pick < 90) ft = FRAME_W'($urandom_range(40, 7));
        else                ft = FRAME_W'($urandom_range(65535));
        send_request(OP_START, CH_W'($urandom_range(7)), COLOR_W'($urandom_range(32767)),
                     COLOR_W'($urandom_range(32767)), ft);
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      fade_active[c]  = 1'b0;
      fade_from[c]    = '0;
      fade_to[c]      = '0;
      fade_len[c]     = '0;
      fade_elapsed[c] = '0;
    end
    mismatch_count = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_START;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_tick();
    test_instant_fades();
    test_extreme_fades();
    test_restart_active();
    test_all_channels();
    wait_drained();

    test_random_phase(57, 0, 0);
    test_random_phase(57, 84, 0);
    test_random_phase(57, 0, 84);
    test_random_phase(57, 18, 18);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
